/* rtl/lep_pkg.sv */
// lep_pkg: shared types, constants and the 4B/5B code table of the line encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package lep_pkg;

    // Coding modes held in the coding_mode register
    localparam logic [1:0] MODE_NRZ  = 2'd0;
    localparam logic [1:0] MODE_NRZI = 2'd1;
    localparam logic [1:0] MODE_MAN  = 2'd2;
    localparam logic [1:0] MODE_4B5B = 2'd3;

    // Register index decoded from paddr[2]
    localparam logic REG_CODING_MODE = 1'b0;

    localparam int BITS_PER_BYTE = 8;
    localparam int SYM_MAX       = 10;   // symbols per byte in 4B/5B mode
    localparam int CNT_W         = 4;    // holds SYM_MAX

    // Job queue between front and serializer
    localparam int QUEUE_DEPTH   = 2;
    localparam int Q_CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // One byte's worth of work for the serializer, symbols left-aligned
    typedef struct packed {
        logic [1:0]         mode;
        logic [SYM_MAX-1:0] word;
    } t_job;

    // Queue status seen by the top level
    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               full;
        logic               empty;
    } t_q_stat;

    // Serializer status seen by the top level
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] cnt;
    } t_back_stat;

    // Standard 4B/5B data table
    function automatic logic [4:0] f_code_4b5b(input logic [3:0] nib);
        logic [4:0] code;
        unique case (nib)
            4'h0: code = 5'b11110;
            4'h1: code = 5'b01001;
            4'h2: code = 5'b10100;
            4'h3: code = 5'b10101;
            4'h4: code = 5'b01010;
            4'h5: code = 5'b01011;
            4'h6: code = 5'b01110;
            4'h7: code = 5'b01111;
            4'h8: code = 5'b10010;
            4'h9: code = 5'b10011;
            4'hA: code = 5'b10110;
            4'hB: code = 5'b10111;
            4'hC: code = 5'b11010;
            4'hD: code = 5'b11011;
            4'hE: code = 5'b11100;
            4'hF: code = 5'b11101;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* rtl/lep_front.sv */
// lep_front: classifies an incoming byte into a serializer job.
// Depends on lep_pkg (t_job, mode codes, 4B/5B table).
`default_nettype none

module lep_front
    import lep_pkg::*;
(
    input  wire logic [1:0]               i_mode,
    input  wire logic [BITS_PER_BYTE-1:0] i_data_byte,
    output t_job                          o_job
);

    always_comb begin
        o_job.mode = i_mode;
        if (i_mode == MODE_4B5B) begin
            o_job.word = {f_code_4b5b(i_data_byte[7:4]), f_code_4b5b(i_data_byte[3:0])};
        end else begin
            // plain bit modes: byte left-aligned, two spare low bits
            o_job.word = {i_data_byte, (SYM_MAX - BITS_PER_BYTE)'(0)};
        end
    end

endmodule

`default_nettype wire

/* rtl/lep_queue.sv */
// lep_queue: small job FIFO between the front and the serializer.
// Depends on lep_pkg (t_job, t_q_stat, QUEUE_DEPTH).
`default_nettype none

module lep_queue
    import lep_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_job,
    output wire logic o_valid,
    output t_q_stat   o_stat
);

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count,  n_count;

    logic push_ok, pop_ok;

    assign push_ok = i_push && (r_count != Q_CNT_W'(DEPTH));
    assign pop_ok  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (push_ok && !pop_ok) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd_ptr];
    assign o_valid      = (r_count != '0);
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == Q_CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

`default_nettype wire

/* rtl/lep_back.sv */
// lep_back: serializer; one line symbol per cycle unless stalled; tracks the NRZI level.
// Depends on lep_pkg (t_job, t_back_stat, mode codes).
`default_nettype none

module lep_back
    import lep_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_job_valid,
    output wire logic o_job_pop,
    output wire logic o_valid,
    input  wire logic i_ready,
    output wire logic o_code_bit,
    output wire logic o_level_first,
    output wire logic o_level_second,
    output wire logic o_last_bit,
    output t_back_stat o_stat
);

    logic               r_busy,  n_busy;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [1:0]         r_mode,  n_mode;
    logic [SYM_MAX-1:0] r_word,  n_word;
    logic               r_level, n_level;
    logic               r_o_valid, n_o_valid;
    logic               r_code, r_first, r_second, r_last;

    logic out_free, emit, sym_bit, sym_last, pop, lv_first, lv_second;

    assign out_free = !r_o_valid || i_ready;
    assign emit     = r_busy && out_free;
    assign sym_bit  = r_word[SYM_MAX-1];
    assign sym_last = (r_cnt == CNT_W'(1));
    // take the next job when idle, or as the current one sends its last symbol
    assign pop      = i_job_valid && (!r_busy || (emit && sym_last));

    always_comb begin
        unique case (r_mode) inside
            MODE_NRZ: begin
                lv_first  = sym_bit;
                lv_second = sym_bit;
            end
            MODE_MAN: begin
                lv_first  = sym_bit;
                lv_second = ~sym_bit;
            end
            MODE_NRZI, MODE_4B5B: begin
                lv_first  = r_level;
                lv_second = r_level ^ sym_bit;
            end
        endcase
    end

    always_comb begin
        n_busy    = r_busy;
        n_cnt     = r_cnt;
        n_mode    = r_mode;
        n_word    = r_word;
        n_level   = r_level;
        n_o_valid = r_o_valid && !i_ready;
        if (emit) begin
            n_o_valid = 1'b1;
            n_word    = {r_word[SYM_MAX-2:0], 1'b0};
            n_cnt     = r_cnt - CNT_W'(1);
            if (sym_last) begin
                n_busy = 1'b0;
            end
            if (r_mode == MODE_NRZI || r_mode == MODE_4B5B) begin
                n_level = lv_second;
            end
        end
        if (pop) begin
            n_busy = 1'b1;
            n_mode = i_job.mode;
            n_word = i_job.word;
            n_cnt  = (i_job.mode == MODE_4B5B) ? CNT_W'(SYM_MAX) : CNT_W'(BITS_PER_BYTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_mode    <= MODE_NRZ;
            r_level   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_cnt     <= n_cnt;
            r_mode    <= n_mode;
            r_level   <= n_level;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (emit) begin
            r_code   <= sym_bit;
            r_first  <= lv_first;
            r_second <= lv_second;
            r_last   <= sym_last;
        end
    end

    assign o_job_pop      = pop;
    assign o_valid        = r_o_valid;
    assign o_code_bit     = r_code;
    assign o_level_first  = r_first;
    assign o_level_second = r_second;
    assign o_last_bit     = r_last;
    assign o_stat.busy    = r_busy;
    assign o_stat.cnt     = r_cnt;

endmodule

`default_nettype wire

/* rtl/line_encoder_4b5b_nrzi_manchester_top.sv */
// line_encoder_4b5b_nrzi_manchester_top: NRZ / NRZI / Manchester / 4B5B+NRZI line encoder.
// Depends on lep_pkg, lep_front, lep_queue, lep_back.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------------------------
//   byte in   | i_valid / o_ready    | i_data_byte[7:0]
//   symbol out| o_valid / i_ready    | o_code_bit, o_level_first, o_level_second,
//             |                      | o_last_bit
//   config    | psel/penable/pwrite  | paddr[2:0], pwdata[31:0], prdata[31:0]
//
// Each byte yields 8 symbols (NRZ, NRZI, Manchester) or 10 (4B/5B), one symbol per
// cycle from the serializer while the output is not stalled.
// The front classifies a byte in the accept cycle and pushes it into a
// QUEUE_DEPTH-entry job queue; o_ready is low only while that queue is full.
// An accepted byte passes the job queue and the serializer's shift register on its way
// out; back-to-back jobs stream with no gap. Output stalls hold the symbol register.
// Reset (synchronous, active low) empties the queue, clears the mode to NRZ and
// drives the line level low.
`default_nettype none

module line_encoder_4b5b_nrzi_manchester_top
    import lep_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // byte input
    input  wire logic                     i_valid,
    output wire logic                     o_ready,
    input  wire logic [BITS_PER_BYTE-1:0] i_data_byte,
    // symbol output
    output wire logic                     o_valid,
    input  wire logic                     i_ready,
    output wire logic                     o_code_bit,
    output wire logic                     o_level_first,
    output wire logic                     o_level_second,
    output wire logic                     o_last_bit,
    // register port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output wire logic [31:0]              prdata,
    output wire logic                     pready
);

    // coding_mode register; sampled into each job at accept time
    logic [1:0] r_mode;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NRZ;
        end else if (cfg_wr && paddr[2] == REG_CODING_MODE) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CODING_MODE) ? {30'd0, r_mode} : 32'd0;

    // front: classify the byte into a job
    t_job       front_job;
    t_job       q_job;
    logic       q_valid;
    logic       q_pop;
    logic       push;
    t_q_stat    q_stat;
    t_back_stat b_stat;

    lep_front u_front (
        .i_mode      (r_mode),
        .i_data_byte (i_data_byte),
        .o_job       (front_job)
    );

    assign o_ready = !q_stat.full;
    assign push    = i_valid && o_ready;

    lep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_valid (q_valid),
        .o_stat  (q_stat)
    );

    // back: serialize one symbol per cycle into the output register unless it is stalled
    lep_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (q_job),
        .i_job_valid    (q_valid),
        .o_job_pop      (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_bit     (o_code_bit),
        .o_level_first  (o_level_first),
        .o_level_second (o_level_second),
        .o_last_bit     (o_last_bit),
        .o_stat         (b_stat)
    );

    // queue occupancy never exceeds its depth
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= Q_CNT_W'(QUEUE_DEPTH))
        else $error("job queue over depth");

    // an accepted byte with no pop grows the queue by exactly one
    a_q_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + Q_CNT_W'(1)))
        else $error("queue count did not follow push");

    // an idle serializer has no symbols pending, a busy one at most ten
    a_back_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!b_stat.busy |-> b_stat.cnt == '0) and (b_stat.cnt <= CNT_W'(SYM_MAX)))
        else $error("serializer count inconsistent");

endmodule

`default_nettype wire

/* bench/line_encoder_4b5b_nrzi_manchester_top_tb.sv */
// Self-checking bench for the NRZ / NRZI / Manchester / 4B5B line encoder.
// Depends on lep_pkg and line_encoder_4b5b_nrzi_manchester_top only.
`timescale 1ns / 1ps

module line_encoder_4b5b_nrzi_manchester_top_tb;
    import lep_pkg::*;

    localparam int CLK_HALF = 6;

    // byte addresses of the register port
    localparam logic [2:0] ADDR_CODING_MODE = 3'd0;
    localparam logic [2:0] ADDR_NO_REG      = 3'd4;

    // 4B/5B data table, nibble n at bits [5n+4:5n]
    localparam logic [79:0] CODE_5B = {
        5'b11101, 5'b11100, 5'b11011, 5'b11010,
        5'b10111, 5'b10110, 5'b10011, 5'b10010,
        5'b01111, 5'b01110, 5'b01011, 5'b01010,
        5'b10101, 5'b10100, 5'b01001, 5'b11110
    };

    typedef struct packed {
        logic code;
        logic first;
        logic second;
        logic last;
    } t_symbol;

    // directed row: symbol k sits at bit 9-k of the typed words
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
        logic       typed;
        logic [9:0] code_w;
        logic [9:0] first_w;
        logic [9:0] second_w;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    wire         o_ready;
    logic [7:0]  i_data_byte;
    wire         o_valid;
    logic        i_ready;
    wire         o_code_bit;
    wire         o_level_first;
    wire         o_level_second;
    wire         o_last_bit;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    // shadow of the block's state
    logic [1:0]  coding_mode_q;
    logic        line_level_q;

    t_symbol     symbols_due[$];
    t_dir_row    dir_tab[$];

    int err_cnt;
    int symbols_checked;
    int items_by_mode[4];
    int in_stall_cycles;
    int reg_writes;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_req;

    line_encoder_4b5b_nrzi_manchester_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_code_bit     (o_code_bit),
        .o_level_first  (o_level_first),
        .o_level_second (o_level_second),
        .o_last_bit     (o_last_bit),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #6_000_000;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

    // Cycles to wait before the next item: pct is the chance of any gap at all.
    function automatic int draw_gap(input int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(1, 11);
        return 0;
    endfunction

    // Expected line symbols of one byte in the current mode; advances the
    // NRZI line level for modes 1 and 3 only.
    task automatic encode_line_byte(input logic [7:0] d, output logic [9:0] code_w,
                                    output logic [9:0] first_w,
                                    output logic [9:0] second_w, output int n);
        logic b;
        code_w   = '0;
        first_w  = '0;
        second_w = '0;
        if (coding_mode_q == MODE_4B5B) begin
            code_w = {CODE_5B[d[7:4]*5 +: 5], CODE_5B[d[3:0]*5 +: 5]};
            n      = 10;
        end else begin
            code_w = {d, 2'b00};
            n      = BITS_PER_BYTE;
        end
        for (int k = 0; k < n; k++) begin
            b = code_w[9-k];
            case (coding_mode_q)
                MODE_NRZ: begin
                    first_w[9-k]  = b;
                    second_w[9-k] = b;
                end
                MODE_MAN: begin
                    first_w[9-k]  = b;
                    second_w[9-k] = ~b;
                end
                default: begin
                    // NRZI: hold on 0, toggle mid-bit on 1
                    first_w[9-k]  = line_level_q;
                    second_w[9-k] = line_level_q ^ b;
                    line_level_q  = line_level_q ^ b;
                end
            endcase
        end
    endtask

    // Register port: setup then access; pready is tied high by the block.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only register 0 exists, other indexes are dropped
        if (addr[2] == REG_CODING_MODE)
            coding_mode_q = value[1:0];
        reg_writes++;
    endtask

    task automatic reg_read_check(input logic [2:0] addr);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {30'd0, coding_mode_q}) begin
            $display("%0t: coding_mode readback expected %0h actual %0h",
                     $time, {30'd0, coding_mode_q}, prdata);
            err_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one byte, hold it until accepted, then queue its symbols.
    task automatic send_item(input t_dir_row row);
        int         gap;
        int         n;
        logic [9:0] code_w;
        logic [9:0] first_w;
        logic [9:0] second_w;
        t_symbol    s;
        @(negedge i_clk);
        gap = draw_gap(tx_idle_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= row.data;
        do @(posedge i_clk); while (!o_ready);
        encode_line_byte(row.data, code_w, first_w, second_w, n);
        if (row.typed) begin
            code_w   = row.code_w;
            first_w  = row.first_w;
            second_w = row.second_w;
        end
        for (int k = 0; k < n; k++) begin
            s.code   = code_w[9-k];
            s.first  = first_w[9-k];
            s.second = second_w[9-k];
            s.last   = (k == n - 1);
            symbols_due.push_back(s);
        end
        items_by_mode[coding_mode_q]++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Mode writes only land once every queued symbol has left the block.
    task automatic wait_drained();
        while (symbols_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        release_input();
        wait_drained();
        reg_write(ADDR_CODING_MODE, {30'($urandom_range(0, 32'h3FFF_FFFF)), mode});
        reg_read_check(ADDR_CODING_MODE);
    endtask

    task automatic add_row(input logic [1:0] mode, input logic [7:0] d, input logic typed,
                           input logic [9:0] c, input logic [9:0] f, input logic [9:0] s);
        t_dir_row r;
        r.mode     = mode;
        r.data     = d;
        r.typed    = typed;
        r.code_w   = c;
        r.first_w  = f;
        r.second_w = s;
        dir_tab.push_back(r);
    endtask

    // Output checker: every accepted symbol against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_ready)
                in_stall_cycles++;
            if (o_valid && i_ready) begin
                if (symbols_due.size() == 0) begin
                    $display("%0t: symbol with nothing expected, actual code %b lvl %b%b last %b",
                             $time, o_code_bit, o_level_first, o_level_second, o_last_bit);
                    err_cnt++;
                end else begin
                    t_symbol exp_s;
                    exp_s = symbols_due.pop_front();
                    symbols_checked++;
                    if (o_code_bit !== exp_s.code) begin
                        $display("%0t: code_bit expected %b actual %b",
                                 $time, exp_s.code, o_code_bit);
                        err_cnt++;
                    end
                    if (o_level_first !== exp_s.first) begin
                        $display("%0t: level_first expected %b actual %b",
                                 $time, exp_s.first, o_level_first);
                        err_cnt++;
                    end
                    if (o_level_second !== exp_s.second) begin
                        $display("%0t: level_second expected %b actual %b",
                                 $time, exp_s.second, o_level_second);
                        err_cnt++;
                    end
                    if (o_last_bit !== exp_s.last) begin
                        $display("%0t: last_bit expected %b actual %b",
                                 $time, exp_s.last, o_last_bit);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Symbol receiver: random per-symbol stalls, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = draw_gap(rx_idle_pct);
            if (rx_hold_req > 0) begin
                gap         = gap + rx_hold_req;
                rx_hold_req = 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Main sequence: reset, register checks, directed table, random phases, drain, verdict.
    initial begin
        t_dir_row r;
        logic [1:0] phase_mode;
        int drain;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_data_byte     = '0;
        i_ready         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        coding_mode_q   = MODE_NRZ;
        line_level_q    = 1'b0;
        err_cnt         = 0;
        symbols_checked = 0;
        in_stall_cycles = 0;
        reg_writes      = 0;
        tx_idle_pct     = 40;
        rx_idle_pct     = 40;
        rx_hold_req     = 0;
        for (int m = 0; m < 4; m++) items_by_mode[m] = 0;

        // Directed rows. Typed ones follow straight from the coding rules with
        // the line level still low from reset (NRZ and Manchester leave it alone).
        add_row(MODE_NRZ,  8'h00, 1'b1, 10'h000, 10'h000, 10'h000);
        add_row(MODE_NRZ,  8'hFF, 1'b1, 10'h3FC, 10'h3FC, 10'h3FC);
        add_row(MODE_NRZ,  8'hA5, 1'b0, '0, '0, '0);
        add_row(MODE_NRZ,  8'h80, 1'b0, '0, '0, '0);
        add_row(MODE_MAN,  8'h00, 1'b1, 10'h000, 10'h000, 10'h3FC);
        add_row(MODE_MAN,  8'hFF, 1'b1, 10'h3FC, 10'h3FC, 10'h000);
        add_row(MODE_MAN,  8'h5A, 1'b0, '0, '0, '0);
        add_row(MODE_MAN,  8'h01, 1'b0, '0, '0, '0);
        add_row(MODE_NRZI, 8'h00, 1'b1, 10'h000, 10'h000, 10'h000);
        add_row(MODE_NRZI, 8'hFF, 1'b1, 10'h3FC, 10'h154, 10'h2A8);
        add_row(MODE_NRZI, 8'h01, 1'b0, '0, '0, '0);
        add_row(MODE_NRZI, 8'h80, 1'b0, '0, '0, '0);
        // 4B/5B: every nibble code in the high or the low position
        add_row(MODE_4B5B, 8'h00, 1'b0, '0, '0, '0);
        add_row(MODE_4B5B, 8'h01, 1'b0, '0, '0, '0);
        add_row(MODE_4B5B, 8'h23, 1'b0, '0, '0, '0);
        add_row(MODE_4B5B, 8'h45, 1'b0, '0, '0, '0);
        add_row(MODE_4B5B, 8'h67, 1'b0, '0, '0, '0);
        add_row(MODE_4B5B, 8'h89, 1'b0, '0, '0, '0);
        add_row(MODE_4B5B, 8'hAB, 1'b0, '0, '0, '0);
        add_row(MODE_4B5B, 8'hCD, 1'b0, '0, '0, '0);
        add_row(MODE_4B5B, 8'hEF, 1'b0, '0, '0, '0);
        add_row(MODE_4B5B, 8'hFF, 1'b0, '0, '0, '0);
        // line level carries over from 4B/5B into plain NRZI
        add_row(MODE_NRZI, 8'hA5, 1'b0, '0, '0, '0);
        add_row(MODE_NRZ,  8'h55, 1'b0, '0, '0, '0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset value, then a write to an index with no register behind it
        reg_read_check(ADDR_CODING_MODE);
        reg_write(ADDR_NO_REG, 32'h0000_0003);
        reg_read_check(ADDR_CODING_MODE);

        foreach (dir_tab[i]) begin
            r = dir_tab[i];
            if (r.mode != coding_mode_q)
                set_mode(r.mode);
            send_item(r);
        end

        // Random phases: first four walk all modes, then random ones. Phase 2
        // streams with no input gaps against one long output hold-off.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       phase_mode = MODE_4B5B;
                1:       phase_mode = MODE_NRZ;
                2:       phase_mode = MODE_MAN;
                3:       phase_mode = MODE_NRZI;
                default: phase_mode = $urandom_range(0, 3);
            endcase
            set_mode(phase_mode);
            case (ph % 3)
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 30;
                default: tx_idle_pct = 80;
            endcase
            case ($urandom_range(0, 2))
                0:       rx_idle_pct = 0;
                1:       rx_idle_pct = 30;
                default: rx_idle_pct = 70;
            endcase
            if (ph == 2) begin
                tx_idle_pct = 0;
                rx_hold_req = 300;
            end
            for (int k = 0; k < 48; k++) begin
                r       = '0;
                r.mode  = phase_mode;
                case ($urandom_range(0, 15))
                    0:       r.data = 8'h00;
                    1:       r.data = 8'hFF;
                    default: r.data = $urandom_range(0, 255);
                endcase
                send_item(r);
            end
        end

        release_input();
        drain = 0;
        while (symbols_due.size() != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        if (symbols_due.size() != 0) begin
            $display("%0t: %0d symbols never arrived", $time, symbols_due.size());
            err_cnt++;
        end
        // catch any stray symbol after the last expected one
        repeat (20) @(posedge i_clk);

        $display("Bytes sent: NRZ %0d, NRZI %0d, Manchester %0d, 4B/5B %0d; symbols checked %0d",
                 items_by_mode[MODE_NRZ], items_by_mode[MODE_NRZI],
                 items_by_mode[MODE_MAN], items_by_mode[MODE_4B5B], symbols_checked);
        $display("Register writes %0d, input back-pressure cycles %0d, errors %0d",
                 reg_writes, in_stall_cycles, err_cnt);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
